// ===== rtl/core/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character codes and the sextet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int FifoDepth  = 8;
    localparam int PtrW       = $clog2(FifoDepth);
    localparam int CntW       = $clog2(FifoDepth + 1);
    localparam int MaxPerWord = 3;
    localparam int AcceptMax  = FifoDepth - MaxPerWord;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [5:0] LOWER_BASE   = 6'd26;
    localparam logic [5:0] DIGIT_BASE   = 6'd52;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_CHAR = 2'd1,
        STAT_BAD_PAD  = 2'd2,
        STAT_PARTIAL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        logic [7:0] d;
        s.valid = 1'b1;
        s.value = '0;
        d = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d = c - CHAR_UPPER_A;
            s.value = d[5:0];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d = c - CHAR_LOWER_A;
            s.value = d[5:0] + LOWER_BASE;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            d = c - CHAR_DIGIT_0;
            s.value = d[5:0] + DIGIT_BASE;
        end else if (c == CHAR_PLUS) begin
            s.value = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            s.value = SEXTET_SLASH;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/base64_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 text decoder, one character word in, one decoded byte word out.
// ----------------------------------------------------------------------------
// Input channel: char_code/last_char with char_valid/char_stall. One character
// is taken per cycle while char_stall is low; the state update and up to
// three results are computed in the cycle the word is accepted and written
// into an 8-entry result queue. Output channel: data_byte/has_byte/last_byte/
// status with byte_valid and byte_stall, one result per word, taken from the
// head of the queue, where results are offered in the order written.
// Throughput, while byte_stall is low: one character per cycle sustained; a
// full group of four gives three bytes, drained one per cycle while the next
// characters arrive. char_stall rises while more than five results are queued,
// so a stalled receiver backs the input up after at most two groups; nothing is
// dropped. End of string always gives a result with last_byte set, after which
// the group state and fault flag are back at their reset values. Reset clears
// the group state, the fault flag and the queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic       char_valid,
    output logic       char_stall,
    output logic [7:0] data_byte,
    output logic       has_byte,
    output logic       last_byte,
    output logic [1:0] status,
    output logic       byte_valid,
    input  logic       byte_stall
);

    logic [1:0]  group_pos_reg, group_pos_next;
    logic [17:0] gather_reg, gather_next;
    logic        pad_reg, pad_next;
    logic        faulted_reg, faulted_next;
    status_t     fault_code_reg, fault_code_next;

    result_t     fifo_reg [FifoDepth];
    logic [PtrW-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [CntW-1:0] count_reg;

    result_t     res [MaxPerWord];
    logic [1:0]  n_res;
    sextet_t     sx;
    logic [23:0] grp;
    logic        in_acc, out_acc;

    assign in_acc     = char_valid && !char_stall;
    assign out_acc    = byte_valid && !byte_stall;
    assign char_stall = (count_reg > CntW'(AcceptMax));
    assign byte_valid = (count_reg != '0);

    assign data_byte = fifo_reg[rd_ptr_reg].data_byte;
    assign has_byte  = fifo_reg[rd_ptr_reg].has_byte;
    assign last_byte = fifo_reg[rd_ptr_reg].last_byte;
    assign status    = fifo_reg[rd_ptr_reg].status;

    assign sx = sextet_of(char_code);

    always_comb
    begin
        group_pos_next  = group_pos_reg;
        gather_next     = gather_reg;
        pad_next        = pad_reg;
        faulted_next    = faulted_reg;
        fault_code_next = fault_code_reg;
        n_res           = 2'd0;
        grp             = '0;
        for (int k = 0; k < MaxPerWord; k++)
        begin
            res[k] = '{data_byte: 8'h00, has_byte: 1'b0, last_byte: 1'b0,
                       status: STAT_OK};
        end

        if (faulted_reg)
        begin
            if (last_char)
            begin
                res[0].last_byte = 1'b1;
                res[0].status    = fault_code_reg;
                n_res            = 2'd1;
            end
        end else if (char_code == CHAR_PAD)
        begin
            if (group_pos_reg == 2'd2 && !pad_reg && !last_char)
            begin
                gather_next    = {gather_reg[11:0], 6'd0};
                group_pos_next = 2'd3;
                pad_next       = 1'b1;
            end else if (group_pos_reg == 2'd3 && last_char)
            begin
                grp = {gather_reg, 6'd0};
                res[0].data_byte = grp[23:16];
                res[0].has_byte  = 1'b1;
                if (!pad_reg)
                begin
                    res[1].data_byte = grp[15:8];
                    res[1].has_byte  = 1'b1;
                    res[1].last_byte = 1'b1;
                    n_res            = 2'd2;
                end else
                begin
                    res[0].last_byte = 1'b1;
                    n_res            = 2'd1;
                end
            end else
            begin
                faulted_next    = 1'b1;
                fault_code_next = STAT_BAD_PAD;
                if (last_char)
                begin
                    res[0].last_byte = 1'b1;
                    res[0].status    = STAT_BAD_PAD;
                    n_res            = 2'd1;
                end
            end
        end else if (!sx.valid || pad_reg)
        begin
            faulted_next    = 1'b1;
            fault_code_next = sx.valid ? STAT_BAD_PAD : STAT_BAD_CHAR;
            if (last_char)
            begin
                res[0].last_byte = 1'b1;
                res[0].status    = fault_code_next;
                n_res            = 2'd1;
            end
        end else if (group_pos_reg == 2'd3)
        begin
            grp = {gather_reg, sx.value};
            res[0].data_byte = grp[23:16];
            res[0].has_byte  = 1'b1;
            res[1].data_byte = grp[15:8];
            res[1].has_byte  = 1'b1;
            res[2].data_byte = grp[7:0];
            res[2].has_byte  = 1'b1;
            res[2].last_byte = last_char;
            n_res            = 2'd3;
            group_pos_next   = 2'd0;
            gather_next      = '0;
        end else
        begin
            gather_next    = {gather_reg[11:0], sx.value};
            group_pos_next = group_pos_reg + 2'd1;
            if (last_char)
            begin
                res[0].last_byte = 1'b1;
                res[0].status    = STAT_PARTIAL;
                n_res            = 2'd1;
            end
        end

        if (last_char)
        begin
            group_pos_next  = 2'd0;
            gather_next     = '0;
            pad_next        = 1'b0;
            faulted_next    = 1'b0;
            fault_code_next = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos_reg  <= '0;
            gather_reg     <= '0;
            pad_reg        <= 1'b0;
            faulted_reg    <= 1'b0;
            fault_code_reg <= STAT_OK;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
        end else
        begin
            if (in_acc)
            begin
                group_pos_reg  <= group_pos_next;
                gather_reg     <= gather_next;
                pad_reg        <= pad_next;
                faulted_reg    <= faulted_next;
                fault_code_reg <= fault_code_next;
                wr_ptr_reg     <= wr_ptr_reg + PtrW'(n_res);
            end
            if (out_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_reg + (in_acc ? CntW'(n_res) : CntW'(0))
                         - (out_acc ? CntW'(1) : CntW'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int k = 0; k < MaxPerWord; k++)
            begin
                if (k < int'(n_res))
                begin
                    fifo_reg[wr_ptr_reg + PtrW'(k)] <= res[k];
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(FifoDepth))
        else $error("result queue overflow");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last_char |=> group_pos_reg == 2'd0 && !faulted_reg && !pad_reg)
        else $error("state not cleared after end of string");

    a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && faulted_reg && !last_char |=> count_reg <= $past(count_reg))
        else $error("result produced while faulted");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && has_byte |-> status == STAT_OK)
        else $error("data result with nonzero status");

endmodule

// ===== verif/tb_base64_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_top
// Self-checking bench for the base64 stream decoder. Characters are sent one
// word at a time and decoded in a local model. The model queues the bytes and
// markers due, and every word the decoder emits is checked against them in
// order. Directed strings come first, then random strings. Random strings
// are mostly well formed, with some bad characters, misplaced padding and
// noise. Both sides idle at random, and there is a long receiver hold-off
// and a full drain pause.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_top
    import b64d_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    RandChars  = 255;
    localparam int    CycleLimit = 200000;
    localparam int    HoldAt     = 60;
    localparam int    HoldLen    = 80;
    localparam string Alphabet   =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    class b64_byte_board;
        logic [1:0]  grp_pos;
        logic [17:0] gather;
        logic [1:0]  pads;
        logic        faulted;
        status_t     fcode;
        result_t     bytes_due[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            grp_pos = '0;
            gather  = '0;
            pads    = '0;
            faulted = 1'b0;
            fcode   = STAT_OK;
        endfunction

        static function int sextet_value(logic [7:0] c);
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                return int'(c - CHAR_UPPER_A);
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                return int'(c - CHAR_LOWER_A) + int'(LOWER_BASE);
            if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
                return int'(c - CHAR_DIGIT_0) + int'(DIGIT_BASE);
            if (c == CHAR_PLUS)
                return int'(SEXTET_PLUS);
            if (c == CHAR_SLASH)
                return int'(SEXTET_SLASH);
            return -1;
        endfunction

        function void due(logic [7:0] b, logic has, logic fin, status_t st);
            result_t r;
            r.data_byte = b;
            r.has_byte  = has;
            r.last_byte = fin;
            r.status    = st;
            bytes_due.push_back(r);
        endfunction

        function void fault(status_t code, logic fin);
            if (!faulted)
            begin
                faulted = 1'b1;
                fcode   = code;
            end
            if (fin)
            begin
                due(8'h00, 1'b0, 1'b1, fcode);
                clear();
            end
        endfunction

        function void note_char(logic [7:0] c, logic fin);
            int          v;
            logic [23:0] g;
            if (faulted)
            begin
                if (fin)
                begin
                    due(8'h00, 1'b0, 1'b1, fcode);
                    clear();
                end
                return;
            end
            if (c == CHAR_PAD)
            begin
                if (grp_pos == 2'd2 && pads == 2'd0 && !fin)
                begin
                    gather  = {gather[11:0], 6'd0};
                    grp_pos = 2'd3;
                    pads    = 2'd1;
                    return;
                end
                if (grp_pos == 2'd3 && fin)
                begin
                    g = {gather, 6'd0};
                    if (pads == 2'd0)
                    begin
                        due(g[23:16], 1'b1, 1'b0, STAT_OK);
                        due(g[15:8], 1'b1, 1'b1, STAT_OK);
                    end
                    else
                        due(g[23:16], 1'b1, 1'b1, STAT_OK);
                    clear();
                    return;
                end
                fault(STAT_BAD_PAD, fin);
                return;
            end
            v = sextet_value(c);
            if (v < 0)
            begin
                fault(STAT_BAD_CHAR, fin);
                return;
            end
            if (pads != 2'd0)
            begin
                fault(STAT_BAD_PAD, fin);
                return;
            end
            if (grp_pos == 2'd3)
            begin
                g = {gather, v[5:0]};
                due(g[23:16], 1'b1, 1'b0, STAT_OK);
                due(g[15:8], 1'b1, 1'b0, STAT_OK);
                due(g[7:0], 1'b1, fin, STAT_OK);
                if (fin)
                    clear();
                else
                begin
                    grp_pos = 2'd0;
                    gather  = '0;
                end
                return;
            end
            gather  = {gather[11:0], v[5:0]};
            grp_pos = grp_pos + 2'd1;
            if (fin)
            begin
                due(8'h00, 1'b0, 1'b1, STAT_PARTIAL);
                clear();
            end
        endfunction

        function void check_byte(logic [7:0] b, logic has, logic fin, logic [1:0] st);
            result_t e;
            if (bytes_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, %s byte=%02h has=%0b",
                         $time, "actual", b, has);
                $display("%0t: unexpected word: actual last=%0b status=%0d",
                         $time, fin, st);
                return;
            end
            e = bytes_due.pop_front();
            if (b !== e.data_byte)
            begin
                errors++;
                $display("%0t: data_byte mismatch: expected %02h, actual %02h",
                         $time, e.data_byte, b);
            end
            if (has !== e.has_byte)
            begin
                errors++;
                $display("%0t: has_byte mismatch: expected %0b, actual %0b",
                         $time, e.has_byte, has);
            end
            if (fin !== e.last_byte)
            begin
                errors++;
                $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                         $time, e.last_byte, fin);
            end
            if (st !== e.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d (%s), actual %0d",
                         $time, e.status, e.status.name(), st);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic [7:0] char_code;
    logic       last_char;
    logic       char_valid;
    logic       char_stall;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
    logic [1:0] status;
    logic       byte_valid;
    logic       byte_stall;

    b64_byte_board board;
    logic [7:0]    text[$];
    int            chars_sent;
    bit            calm;

    base64_stream_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (char_code),
        .last_char  (last_char),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last_byte  (last_byte),
        .status     (status),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off, none while calm
    initial
    begin
        int hold_left;
        bit held;
        hold_left  = 0;
        held       = 1'b0;
        byte_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && chars_sent >= HoldAt)
            begin
                held      = 1'b1;
                hold_left = HoldLen;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                byte_stall = 1'b1;
            end
            else if (calm)
                byte_stall = 1'b0;
            else
                byte_stall = ($urandom_range(0, 99) < 28);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
            board.check_byte(data_byte, has_byte, last_byte, status);
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 28)
        begin
            char_valid = 1'b0;
            @(negedge clk);
        end
        char_valid = 1'b1;
        char_code  = c;
        last_char  = fin;
        do
            @(posedge clk);
        while (char_stall);
        board.note_char(c, fin);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] b64_char();
        return Alphabet[$urandom_range(0, 63)];
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_PAD || b64_byte_board::sextet_value(b) >= 0);
        return b;
    endfunction

    initial
    begin
        int  rand_chars;
        int  kind;
        int  n;
        bit  paused;
        board      = new();
        chars_sent = 0;
        calm       = 1'b0;
        rand_chars = 0;
        paused     = 1'b0;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_code  = 8'h00;
        last_char  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_text("TWFu");
        send_text("QQ==");
        send_text("QUI=");
        send_char(8'h41, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h42, 1'b1);
        send_text("A=B");
        send_text("AB");
        send_char(8'h00, 1'b1);
        send_text("+/9z=");

        while (rand_chars < RandChars)
        begin
            calm = (rand_chars >= 120 && rand_chars < 180);
            if (!paused && rand_chars >= 210)
            begin
                paused = 1'b1;
                @(negedge clk);
                char_valid = 1'b0;
                while (board.bytes_due.size() != 0)
                    @(posedge clk);
            end
            text.delete();
            kind = $urandom_range(0, 9);
            repeat ($urandom_range(0, 2) * 4)
                text.push_back(b64_char());
            case (kind)
                6:
                    repeat ($urandom_range(1, 3))
                        text.push_back(b64_char());
                7, 8:
                begin
                    repeat (4)
                        text.push_back(b64_char());
                    n = $urandom_range(0, text.size() - 1);
                    text[n] = (kind == 7) ? bad_char() : CHAR_PAD;
                end
                9:
                    repeat ($urandom_range(1, 6))
                    begin
                        case ($urandom_range(0, 2))
                            0:       text.push_back(8'($urandom_range(0, 255)));
                            1:       text.push_back(CHAR_PAD);
                            default: text.push_back(b64_char());
                        endcase
                    end
                default:
                begin
                    n = $urandom_range(0, 2);
                    repeat (4 - n)
                        text.push_back(b64_char());
                    repeat (n)
                        text.push_back(CHAR_PAD);
                end
            endcase
            foreach (text[i])
                send_char(text[i], i == text.size() - 1);
            rand_chars += text.size();
        end
        calm = 1'b0;
        @(negedge clk);
        char_valid = 1'b0;

        while (board.bytes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
